FILE: design/tclf_pkg.sv
// Package for the telnet control line filter: byte codes, parser modes,
// result item and decode bundle types, used by the decode, result buffer and top files.
`timescale 1ns / 1ps

package tclf_pkg;

	localparam logic [7:0] CODE_IAC  = 8'd255;
	localparam logic [7:0] CODE_DONT = 8'd254;
	localparam logic [7:0] CODE_DO   = 8'd253;
	localparam logic [7:0] CODE_WONT = 8'd252;
	localparam logic [7:0] CODE_WILL = 8'd251;
	localparam logic [7:0] CHAR_NUL  = 8'h00;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_CR   = 8'h0D;

	localparam int unsigned MAX_RES = 3;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_IAC    = 3'd1,
		MODE_SKIP   = 3'd2,
		MODE_WILL   = 3'd3,
		MODE_DO     = 3'd4
	} mode_t;

	typedef struct packed {
		logic       dest;
		logic [7:0] out_byte;
		logic       line_end;
		logic       last;
	} res_t;

	// Decoded item: up to three results plus the parser state to keep.
	typedef struct packed {
		res_t [MAX_RES-1:0] res;
		logic [1:0]         cnt;
		mode_t              mode_nxt;
		logic               held_nxt;
	} dec_t;

	function automatic res_t mk_res(input logic d, input logic [7:0] b,
			input logic le, input logic l);
		res_t r;
		r.dest     = d;
		r.out_byte = b;
		r.line_end = le;
		r.last     = l;
		return r;
	endfunction

endpackage

FILE: design/tclf_if.sv
// Valid/ready channel interfaces for input bytes and result items.
// Depends on nothing.
`timescale 1ns / 1ps

interface tclf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface tclf_out_if;
	logic       valid;
	logic       ready;
	logic       dest;
	logic [7:0] out_byte;
	logic       line_end;
	logic       last;

	modport source (output valid, output dest, output out_byte, output line_end,
		output last, input ready);
	modport sink   (input valid, input dest, input out_byte, input line_end,
		input last, output ready);
endinterface

FILE: design/tclf_decode.sv
// Combinational decode of one input byte against the parser state.
// Depends on tclf_pkg.
`timescale 1ns / 1ps

module tclf_decode (
	input  tclf_pkg::mode_t mode,
	input  logic            held_cr,
	input  logic [7:0]      in_byte,
	output tclf_pkg::dec_t  dec
);

	logic       data_go;
	logic [7:0] data_b;

	assign data_b = (in_byte == tclf_pkg::CHAR_NUL) ? tclf_pkg::CHAR_LF : in_byte;

	always_comb begin
		dec          = '0;
		dec.mode_nxt = tclf_pkg::MODE_NORMAL;
		dec.held_nxt = held_cr;
		data_go      = 1'b0;

		unique case (mode)
			tclf_pkg::MODE_IAC: begin
				if (in_byte == tclf_pkg::CODE_IAC) begin
					data_go = 1'b1;
				end else if (in_byte == tclf_pkg::CODE_DONT ||
						in_byte == tclf_pkg::CODE_WONT) begin
					dec.mode_nxt = tclf_pkg::MODE_SKIP;
				end else if (in_byte == tclf_pkg::CODE_WILL) begin
					dec.mode_nxt = tclf_pkg::MODE_WILL;
				end else if (in_byte == tclf_pkg::CODE_DO) begin
					dec.mode_nxt = tclf_pkg::MODE_DO;
				end
			end
			tclf_pkg::MODE_SKIP: begin
				// drop the option byte
			end
			tclf_pkg::MODE_WILL, tclf_pkg::MODE_DO: begin
				dec.res[0] = tclf_pkg::mk_res(1'b1, tclf_pkg::CODE_IAC, 1'b0, 1'b0);
				dec.res[1] = tclf_pkg::mk_res(1'b1,
					(mode == tclf_pkg::MODE_WILL) ? tclf_pkg::CODE_DONT
					                              : tclf_pkg::CODE_WONT,
					1'b0, 1'b0);
				dec.res[2] = tclf_pkg::mk_res(1'b1, in_byte, 1'b0, 1'b1);
				dec.cnt    = 2'd3;
			end
			default: begin
				if (in_byte == tclf_pkg::CODE_IAC) begin
					dec.mode_nxt = tclf_pkg::MODE_IAC;
				end else begin
					data_go = 1'b1;
				end
			end
		endcase

		if (data_go) begin
			if (in_byte == tclf_pkg::CHAR_LF) begin
				// a held CR right before LF is dropped
				dec.res[0]   = tclf_pkg::mk_res(1'b0, 8'd0, 1'b1, 1'b1);
				dec.cnt      = 2'd1;
				dec.held_nxt = 1'b0;
			end else if (held_cr) begin
				dec.res[0] = tclf_pkg::mk_res(1'b0, tclf_pkg::CHAR_CR, 1'b0,
					in_byte == tclf_pkg::CHAR_CR);
				if (in_byte == tclf_pkg::CHAR_CR) begin
					dec.cnt      = 2'd1;
					dec.held_nxt = 1'b1;
				end else begin
					dec.res[1]   = tclf_pkg::mk_res(1'b0, data_b, 1'b0, 1'b1);
					dec.cnt      = 2'd2;
					dec.held_nxt = 1'b0;
				end
			end else if (in_byte == tclf_pkg::CHAR_CR) begin
				dec.held_nxt = 1'b1;
			end else begin
				dec.res[0] = tclf_pkg::mk_res(1'b0, data_b, 1'b0, 1'b1);
				dec.cnt    = 2'd1;
			end
		end
	end

endmodule

FILE: design/tclf_result_buf.sv
// Result register: holds up to three results of one item and hands
// them out one per cycle while the output is ready. Depends on tclf_pkg and tclf_if.
`timescale 1ns / 1ps

module tclf_result_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  tclf_pkg::dec_t    dec,
	output logic              ready,
	tclf_out_if.source        out_ch
);

	tclf_pkg::res_t res_q [tclf_pkg::MAX_RES];
	logic [1:0]     cnt_q;
	logic           pop;

	assign pop   = out_ch.valid && out_ch.ready;
	// a new item may load when the last result leaves this cycle
	assign ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= dec.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < tclf_pkg::MAX_RES; i++) begin
				res_q[i] <= dec.res[i];
			end
		end else if (pop) begin
			// advance the queue toward the head
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

	assign out_ch.valid    = (cnt_q != 2'd0);
	assign out_ch.dest     = res_q[0].dest;
	assign out_ch.out_byte = res_q[0].out_byte;
	assign out_ch.line_end = res_q[0].line_end;
	assign out_ch.last     = res_q[0].last;

endmodule

FILE: design/telnet_control_line_filter_unit.sv
// Telnet control line filter, top level. The first result of an item appears
// in the cycle after its input item is accepted. One input item is taken
// per cycle while each item yields at most one result and the output is ready;
// an item with more results holds the input until its last leaves the single output port.
// Reset clears the parser mode to normal data and drops any held CR.
// Depends on tclf_pkg, tclf_if, tclf_decode and tclf_result_buf.
`timescale 1ns / 1ps

module telnet_control_line_filter_unit (
	input  logic       clk,
	input  logic       arst_n,
	tclf_in_if.sink    in_ch,
	tclf_out_if.source out_ch
);

	tclf_pkg::mode_t mode_q;
	logic            held_cr_q;
	tclf_pkg::dec_t  dec;
	logic            buf_ready;
	logic            accept;

	assign in_ch.ready = buf_ready;
	assign accept      = in_ch.valid && buf_ready;

	tclf_decode u_decode (
		.mode    (mode_q),
		.held_cr (held_cr_q),
		.in_byte (in_ch.in_byte),
		.dec     (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= tclf_pkg::MODE_NORMAL;
			held_cr_q <= 1'b0;
		end else if (accept) begin
			mode_q    <= dec.mode_nxt;
			held_cr_q <= dec.held_nxt;
		end
	end

	tclf_result_buf u_result_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.dec    (dec),
		.ready  (buf_ready),
		.out_ch (out_ch)
	);

	// An item is only taken when no result is pending or the pending one is the last of its group and leaving
	a_accept_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!out_ch.valid || (out_ch.ready && out_ch.last)))
		else $error("item accepted while earlier results still pending");

	// The option byte of WILL or DO opens a refusal with IAC
	a_refusal_head: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (mode_q == tclf_pkg::MODE_WILL || mode_q == tclf_pkg::MODE_DO))
		|=> (out_ch.valid && out_ch.dest && out_ch.out_byte == tclf_pkg::CODE_IAC
		&& !out_ch.last))
		else $error("refusal reply does not start with IAC");

	// A line end is always a command line result and the last of its item
	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.line_end) |-> (!out_ch.dest && out_ch.last))
		else $error("line end result malformed");

endmodule
